// File: design/srd_pkg.sv
// Package for the refraction pipeline: fixed field widths and default parameters.
// No dependencies.
package srd_pkg;

    localparam int FRAC_BITS_DEF = 16;  // fraction bits of all fixed-point values
    localparam int IN_W          = 18;  // direction and normal components
    localparam int ETA_W         = 19;  // unsigned index ratio
    localparam int OUT_W         = 20;  // saturated result components
    localparam int PERP_W        = 24;  // saturation width of the perpendicular part

endpackage

// File: design/snell_refract_direction.sv
// Snell-law refraction of a direction vector, fully pipelined, one request per cycle while in_stall is low.
// Depends on srd_pkg (field widths, default fraction bits).
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_stall  | dir_x..z, normal_x..z (s18), eta_ratio (u19)
//  output   | out_valid / out_stall| out_x, out_y, out_z (s20, saturated)
//
// Each square-root stage yields 2 root bits.
// One request is accepted per cycle while in_stall is low.
// Each stage holds its request until the next one is free, so bubbles close up
// and in_stall rises only when every stage is full and the output is stalled.
// Reset clears the valid bits only; the data registers are not reset.
module snell_refract_direction #(
    parameter int FRAC_BITS = srd_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [srd_pkg::IN_W-1:0]   dir_x,
    input  logic signed [srd_pkg::IN_W-1:0]   dir_y,
    input  logic signed [srd_pkg::IN_W-1:0]   dir_z,
    input  logic signed [srd_pkg::IN_W-1:0]   normal_x,
    input  logic signed [srd_pkg::IN_W-1:0]   normal_y,
    input  logic signed [srd_pkg::IN_W-1:0]   normal_z,
    input  logic        [srd_pkg::ETA_W-1:0]  eta_ratio,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [srd_pkg::OUT_W-1:0]  out_x,
    output logic signed [srd_pkg::OUT_W-1:0]  out_y,
    output logic signed [srd_pkg::OUT_W-1:0]  out_z
);

    localparam int F      = FRAC_BITS;
    localparam int IW     = srd_pkg::IN_W;
    localparam int PRW    = srd_pkg::PERP_W;
    localparam int OW     = srd_pkg::OUT_W;
    localparam int PW     = 2 * IW;                                  // d*n product
    localparam int DW     = (PW + 2 > 2 * F + 2) ? PW + 2 : 2 * F + 2; // dot sum
    localparam int CW     = DW - F + 1;                              // cosine
    localparam int TW     = ((IW + F > IW + CW) ? IW + F : IW + CW) + 1;
    localparam int TRW    = TW - F + 1;                              // rounded t
    localparam int EW     = srd_pkg::ETA_W + 1 + TRW;                // eta*t
    localparam int SSW    = 2 * PRW + 2;                             // sum of squares
    localparam int XW     = ((SSW > 2 * F + 1) ? SSW : 2 * F + 1) + 1;
    localparam int NSQ    = (((XW + 1) / 2) + 1) / 2;                // root stages
    localparam int IT     = 2 * NSQ;                                 // root bits
    localparam int XP     = 2 * IT;
    localparam int QW     = IW + IT + 1;                             // n*s product
    localparam int RW     = QW + 2;

    localparam int ST_SQ  = 7;
    localparam int ST_Q   = ST_SQ + NSQ;
    localparam int ST_OUT = ST_Q + 1;
    localparam int NST    = ST_OUT + 1;

    localparam logic signed [DW-1:0] ONE2_D = DW'(1) <<< (2 * F);
    localparam logic signed [XW-1:0] ONE2_X = XW'(1) <<< (2 * F);
    localparam logic signed [EW:0]   PMAX   = (EW + 1)'((1 << (PRW - 1)) - 1);
    localparam logic signed [EW:0]   PMIN   = -(EW + 1)'(1 << (PRW - 1));
    localparam logic signed [RW-1:0] OMAX   = RW'((1 << (OW - 1)) - 1);
    localparam logic signed [RW-1:0] OMIN   = -RW'(1 << (OW - 1));

    typedef struct packed {
        logic [XP-1:0]  x;
        logic [IT+1:0]  rem;
        logic [IT-1:0]  root;
    } sq_state_t;

    // two restoring square-root steps on a (x, remainder, root) triple
    function automatic sq_state_t sqrt_step2(input sq_state_t s);
        sq_state_t     r;
        logic [IT+1:0] cur;
        logic [IT+1:0] trial;
        r = s;
        for (int k = 0; k < 2; k++)
        begin
            cur   = {r.rem[IT-1:0], r.x[XP-1:XP-2]};
            trial = {r.root, 2'b01};
            r.x   = {r.x[XP-3:0], 2'b00};
            if (cur >= trial)
            begin
                r.rem  = cur - trial;
                r.root = {r.root[IT-2:0], 1'b1};
            end
            else
            begin
                r.rem  = cur;
                r.root = {r.root[IT-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // stage enables: a stage loads when it is empty or its successor loads
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        logic nxt;
        nxt = !out_stall;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || nxt;
            nxt   = en[i];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 1: d*n products
    logic signed [IW-1:0]           s1_d_reg [3];
    logic signed [IW-1:0]           s1_n_reg [3];
    logic [srd_pkg::ETA_W-1:0]      s1_eta_reg;
    logic signed [PW-1:0]           s1_prod_reg [3];
    // stage 2: cosine
    logic signed [IW-1:0]           s2_d_reg [3];
    logic signed [IW-1:0]           s2_n_reg [3];
    logic [srd_pkg::ETA_W-1:0]      s2_eta_reg;
    logic signed [CW-1:0]           s2_c_reg;
    // stage 3: t = d + n*c
    logic signed [IW-1:0]           s3_n_reg [3];
    logic [srd_pkg::ETA_W-1:0]      s3_eta_reg;
    logic signed [TRW-1:0]          s3_t_reg [3];
    // stage 4: eta*t
    logic signed [IW-1:0]           s4_n_reg [3];
    logic signed [EW-1:0]           s4_e_reg [3];
    // stage 5: perpendicular part
    logic signed [IW-1:0]           s5_n_reg [3];
    logic signed [PRW-1:0]          s5_p_reg [3];
    // stage 6: squares
    logic signed [IW-1:0]           s6_n_reg [3];
    logic signed [PRW-1:0]          s6_p_reg [3];
    logic signed [2*PRW-1:0]        s6_sq_reg [3];
    // stage 7: root argument
    logic signed [IW-1:0]           s7_n_reg [3];
    logic signed [PRW-1:0]          s7_p_reg [3];
    logic [XW-1:0]                  s7_x_reg;
    // square-root stages
    sq_state_t                      sq_reg   [NSQ];
    logic signed [IW-1:0]           sq_n_reg [NSQ][3];
    logic signed [PRW-1:0]          sq_p_reg [NSQ][3];
    // n*s stage
    logic signed [PRW-1:0]          q_p_reg [3];
    logic signed [QW-1:0]           q_prod_reg [3];
    // output
    logic signed [OW-1:0]           out_reg [3];

    logic signed [IW-1:0]           in_d [3];
    logic signed [IW-1:0]           in_n [3];
    sq_state_t                      sq_in;

    assign in_d = '{dir_x, dir_y, dir_z};
    assign in_n = '{normal_x, normal_y, normal_z};
    assign sq_in = '{x: XP'(s7_x_reg), rem: '0, root: '0};

    logic signed [DW-1:0]  ndot;
    logic signed [DW-1:0]  ndot_c;
    logic signed [DW-1:0]  c_sh;
    logic signed [TW-1:0]  t_sum [3];
    logic signed [EW:0]    e_sh [3];
    logic signed [XW-1:0]  diff;
    logic signed [QW:0]    q_sh [3];
    logic signed [RW-1:0]  r_sum [3];

    always_comb
    begin
        ndot   = -(DW'(s1_prod_reg[0]) + DW'(s1_prod_reg[1]) + DW'(s1_prod_reg[2]));
        ndot_c = (ndot > ONE2_D) ? ONE2_D : ndot;
        c_sh   = (ndot_c + (DW'(1) <<< (F - 1))) >>> F;
        diff   = ONE2_X - $signed(XW'(s6_sq_reg[0]) + XW'(s6_sq_reg[1])
                                  + XW'(s6_sq_reg[2]));
        for (int i = 0; i < 3; i++)
        begin
            t_sum[i] = ((TW'(s2_d_reg[i]) <<< F) + TW'(s2_n_reg[i] * s2_c_reg)
                        + (TW'(1) <<< (F - 1))) >>> F;
            e_sh[i]  = ((EW + 1)'(s4_e_reg[i]) + ((EW + 1)'(1) <<< (F - 1))) >>> F;
            q_sh[i]  = (-((QW + 1)'(q_prod_reg[i])) + ((QW + 1)'(1) <<< (F - 1))) >>> F;
            r_sum[i] = RW'(q_p_reg[i]) + RW'(q_sh[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i]    <= in_d[i];
                s1_n_reg[i]    <= in_n[i];
                s1_prod_reg[i] <= in_d[i] * in_n[i];
            end
            s1_eta_reg <= eta_ratio;
        end
        if (en[1])
        begin
            s2_d_reg   <= s1_d_reg;
            s2_n_reg   <= s1_n_reg;
            s2_eta_reg <= s1_eta_reg;
            s2_c_reg   <= c_sh[CW-1:0];
        end
        if (en[2])
        begin
            s3_n_reg   <= s2_n_reg;
            s3_eta_reg <= s2_eta_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_t_reg[i] <= t_sum[i][TRW-1:0];
            end
        end
        if (en[3])
        begin
            s4_n_reg <= s3_n_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_e_reg[i] <= $signed({1'b0, s3_eta_reg}) * s3_t_reg[i];
            end
        end
        if (en[4])
        begin
            s5_n_reg <= s4_n_reg;
            for (int i = 0; i < 3; i++)
            begin
                priority if (e_sh[i] > PMAX)
                    s5_p_reg[i] <= PMAX[PRW-1:0];
                else if (e_sh[i] < PMIN)
                    s5_p_reg[i] <= PMIN[PRW-1:0];
                else
                    s5_p_reg[i] <= e_sh[i][PRW-1:0];
            end
        end
        if (en[5])
        begin
            s6_n_reg <= s5_n_reg;
            s6_p_reg <= s5_p_reg;
            for (int i = 0; i < 3; i++)
            begin
                s6_sq_reg[i] <= s5_p_reg[i] * s5_p_reg[i];
            end
        end
        if (en[6])
        begin
            s7_n_reg <= s6_n_reg;
            s7_p_reg <= s6_p_reg;
            // magnitude kept: no flag for total internal reflection
            s7_x_reg <= diff[XW-1] ? $unsigned(-diff) : $unsigned(diff);
        end
        if (en[ST_SQ])
        begin
            sq_reg[0]   <= sqrt_step2(sq_in);
            sq_n_reg[0] <= s7_n_reg;
            sq_p_reg[0] <= s7_p_reg;
        end
        for (int k = 1; k < NSQ; k++)
        begin
            if (en[ST_SQ + k])
            begin
                sq_reg[k]   <= sqrt_step2(sq_reg[k-1]);
                sq_n_reg[k] <= sq_n_reg[k-1];
                sq_p_reg[k] <= sq_p_reg[k-1];
            end
        end
        if (en[ST_Q])
        begin
            q_p_reg <= sq_p_reg[NSQ-1];
            for (int i = 0; i < 3; i++)
            begin
                q_prod_reg[i] <= sq_n_reg[NSQ-1][i] * $signed({1'b0, sq_reg[NSQ-1].root});
            end
        end
        if (en[ST_OUT])
        begin
            for (int i = 0; i < 3; i++)
            begin
                priority if (r_sum[i] > OMAX)
                    out_reg[i] <= OMAX[OW-1:0];
                else if (r_sum[i] < OMIN)
                    out_reg[i] <= OMIN[OW-1:0];
                else
                    out_reg[i] <= r_sum[i][OW-1:0];
            end
        end
    end

    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];

endmodule

// File: test/srd_checker.sv
// Checker for the refraction pipeline: watches both channels, predicts each result.
// Depends on srd_pkg for field widths.
`timescale 1ns / 100ps

module srd_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [srd_pkg::IN_W-1:0]   dir_x,
    input  logic signed [srd_pkg::IN_W-1:0]   dir_y,
    input  logic signed [srd_pkg::IN_W-1:0]   dir_z,
    input  logic signed [srd_pkg::IN_W-1:0]   normal_x,
    input  logic signed [srd_pkg::IN_W-1:0]   normal_y,
    input  logic signed [srd_pkg::IN_W-1:0]   normal_z,
    input  logic        [srd_pkg::ETA_W-1:0]  eta_ratio,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [srd_pkg::OUT_W-1:0]  out_x,
    input  logic signed [srd_pkg::OUT_W-1:0]  out_y,
    input  logic signed [srd_pkg::OUT_W-1:0]  out_z,
    output int                                fail_count,
    output int                                pending
);
    localparam int F = srd_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [srd_pkg::OUT_W-1:0] x;
        logic signed [srd_pkg::OUT_W-1:0] y;
        logic signed [srd_pkg::OUT_W-1:0] z;
    } ray_t;

    ray_t refracted_q[$];

    // divide by 2^s, rounding half towards +inf
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic ray_t refract(longint d[3], longint n[3], longint eta);
        longint one2, dp, c, t, sumsq, diff, s;
        longint p[3];
        longint r[3];
        ray_t res;
        one2 = longint'(1) <<< (2 * F);
        dp = -(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]);
        if (dp > one2) dp = one2;
        c = rnd_shift(dp, F);
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = rnd_shift((d[i] <<< F) + n[i] * c, F);
            p[i] = sat(rnd_shift(eta * t, F), srd_pkg::PERP_W);
            sumsq += p[i] * p[i];
        end
        diff = one2 - sumsq;
        if (diff < 0) diff = -diff;
        s = int_sqrt(diff);
        for (int i = 0; i < 3; i++)
            r[i] = sat(p[i] + rnd_shift(-(n[i] * s), F), srd_pkg::OUT_W);
        res.x = r[0][srd_pkg::OUT_W-1:0];
        res.y = r[1][srd_pkg::OUT_W-1:0];
        res.z = r[2][srd_pkg::OUT_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        longint d[3];
        longint n[3];
        ray_t exp_r;
        if (!rst_n)
        begin
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                d[0] = dir_x;    d[1] = dir_y;    d[2] = dir_z;
                n[0] = normal_x; n[1] = normal_y; n[2] = normal_z;
                refracted_q.push_back(refract(d, n, longint'(eta_ratio)));
            end
            if (out_valid && !out_stall)
            begin
                if (refracted_q.size() == 0)
                begin
                    $display("%0t: unexpected result %0d %0d %0d", $time, out_x, out_y, out_z);
                    fail_count++;
                end
                else
                begin
                    exp_r = refracted_q.pop_front();
                    if (exp_r.x !== out_x || exp_r.y !== out_y || exp_r.z !== out_z)
                    begin
                        $display("%0t: mismatch expected %0d %0d %0d actual %0d %0d %0d",
                                 $time, exp_r.x, exp_r.y, exp_r.z, out_x, out_y, out_z);
                        fail_count++;
                    end
                end
            end
        end
        pending = refracted_q.size();
    end
endmodule

// File: test/tb_snell_refract_direction.sv
// Top of the refraction testbench: clock, reset, stimulus and verdict.
// Depends on srd_pkg, snell_refract_direction and srd_checker.
`timescale 1ns / 100ps

module tb_snell_refract_direction;
    localparam int IW = srd_pkg::IN_W;
    localparam int EW = srd_pkg::ETA_W;
    localparam int ONE = 1 << srd_pkg::FRAC_BITS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic signed [IW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic signed [IW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic [EW-1:0] eta_ratio = '0;
    logic in_stall, out_valid;
    logic signed [srd_pkg::OUT_W-1:0] out_x, out_y, out_z;
    int fail_count, pending;
    bit quiet = 0;      // no idling in the last part
    bit hold_long = 0;  // long receiver hold-off
    int stall_left = 0; // cycles left in a receiver idle burst

    always #5 clk = ~clk;

    snell_refract_direction i_dut (.*);

    srd_checker i_chk (.*);

    function automatic int rand_comp(int kind);
        case (kind)
            0: return int'($urandom_range(0, (1 << IW) - 1)) - (1 << (IW - 1));
            1: return int'($urandom_range(0, 2 * ONE)) - ONE;
            default: return int'($urandom_range(0, ONE / 4)) - ONE / 8;
        endcase
    endfunction

    // drive one request and wait for it to be taken
    task automatic send_ray(int dx, dy, dz, nx, ny, nz, int e);
        dir_x <= IW'(dx); dir_y <= IW'(dy); dir_z <= IW'(dz);
        normal_x <= IW'(nx); normal_y <= IW'(ny); normal_z <= IW'(nz);
        eta_ratio <= EW'(e);
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic send_rand(int n);
        int k;
        int c[6];
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            // mostly near-unit vectors, some raw noise
            for (int j = 0; j < 6; j++)
                c[j] = rand_comp(k == 0 ? 0 : (k < 8 ? 1 : 2));
            send_ray(c[0], c[1], c[2], c[3], c[4], c[5],
                     k < 2 ? int'($urandom_range(0, (1 << EW) - 1))
                           : int'($urandom_range(ONE / 2, 2 * ONE)));
        end
    endtask

    // receiver idling
    always @(negedge clk)
    begin
        if (hold_long)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        int mx, mn;
        mx = (1 << (IW - 1)) - 1;
        mn = -(1 << (IW - 1));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: normal incidence, grazing, extremes, zero and large eta
        send_ray(0, 0, -ONE, 0, 0, ONE, ONE);
        send_ray(0, -ONE, 0, 0, ONE, 0, ONE / 2 + ONE / 4);
        send_ray(ONE, 0, 0, 0, 0, ONE, ONE + ONE / 2);
        send_ray(ONE, 0, 0, 0, 0, ONE, 0);
        send_ray(ONE, 0, 0, 0, 0, ONE, -1);
        send_ray(mx, mx, mx, mx, mx, mx, -1);
        send_ray(mn, mn, mn, mn, mn, mn, -1);
        send_ray(mx, mn, mx, mn, mx, mn, -1);
        send_ray(mn, mx, mn, mx, mn, mx, ONE);
        send_ray(mx, mx, mx, mn, mn, mn, ONE);
        send_ray(0, 0, 0, 0, 0, 0, 0);
        send_ray(-1, -1, -1, -1, -1, -1, 1);
        send_ray(0, 0, ONE, 0, 0, ONE, ONE);
        send_ray(ONE / 2, ONE / 2, -ONE / 2, 0, 0, ONE, 2 * ONE);
        send_ray(2 * ONE - 1, 0, 0, mx, 0, 0, ONE);
        send_ray(0, mn, 0, 0, mn, 0, -1);
        // fill the pipe against a held output
        hold_long <= 1'b1;
        fork
            begin
                repeat (60) @(negedge clk);
                hold_long <= 1'b0;
            end
            send_rand(40);
        join
        send_rand(400);
        // sender pause until drained
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        send_rand(300);
        quiet = 1;
        send_rand(160);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
